FILE: rtl/char_lcd_parallel_controller_macros.svh
// Assertion helpers used by the sequencer RTL (clpc_seq)
`ifndef CHAR_LCD_PARALLEL_CONTROLLER_MACROS_SVH
`define CHAR_LCD_PARALLEL_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CLPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/clpc_pkg.sv
package clpc_pkg;

  localparam int WAIT_WIDTH_DEF = 17;
  localparam int CFG_DATA_W     = 17;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT  = 1'd1;

  localparam int SHORT_WAIT_RST = 10;
  localparam int LONG_WAIT_RST  = 65536;

  localparam logic [2:0] ACT_TICK        = 3'd0;
  localparam logic [2:0] ACT_INIT        = 3'd1;
  localparam logic [2:0] ACT_WRITE_INSTR = 3'd2;
  localparam logic [2:0] ACT_WRITE_DATA  = 3'd3;
  localparam logic [2:0] ACT_SET_CURSOR  = 3'd4;

  localparam logic [3:0] INIT_PRE_WAITS = 4'd3;
  localparam logic [3:0] INIT_LAST_STEP = 4'd10;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [4:0] NUM_COLUMNS    = 5'd20;
  localparam logic [2:0] NUM_ROWS       = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_INIT_WAIT,
    PH_INIT_STROBE,
    PH_POLL_PRE,
    PH_POLL_HIGH,
    PH_WRITE_SETUP,
    PH_WRITE_STROBE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       drive;
    logic       rs;
    logic       rw;
    logic       en;
  } pins_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
    logic [2:0] row;
    logic [4:0] column;
    logic [7:0] bus_in;
  } cmd_t;

  typedef struct packed {
    logic       lcd_enable;
    logic       lcd_select;
    logic       lcd_read;
    logic [7:0] bus_out;
    logic       bus_drive;
    logic       ready_res;
    logic       rejected;
  } res_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0, 3'd1, 3'd2, 3'd3: b = 8'h38;
      3'd4:                   b = 8'h0C;
      3'd5:                   b = 8'h01;
      3'd6:                   b = 8'h06;
      default:                b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] row_base(input logic [1:0] r);
    logic [6:0] b;
    case (r)
      2'd0:    b = 7'h00;
      2'd1:    b = 7'h40;
      2'd2:    b = 7'h14;
      2'd3:    b = 7'h54;
      default: b = 7'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/clpc_stream_if.sv
interface clpc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/clpc_cfg.sv
module clpc_cfg #(
  parameter int WAIT_WIDTH = clpc_pkg::WAIT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [clpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [WAIT_WIDTH-1:0]          short_wait,
  output logic [WAIT_WIDTH-1:0]          long_wait
);
  import clpc_pkg::*;

  localparam int    EXT_W  = (WAIT_WIDTH > CFG_DATA_W) ? WAIT_WIDTH : CFG_DATA_W;
  localparam longint WMAX_L = (longint'(1) << WAIT_WIDTH) - 1;
  localparam logic [EXT_W-1:0] WMAX = EXT_W'(WMAX_L);
  localparam logic [WAIT_WIDTH-1:0] SHORT_RST =
    WAIT_WIDTH'((SHORT_WAIT_RST > WMAX_L) ? WMAX_L : longint'(SHORT_WAIT_RST));
  localparam logic [WAIT_WIDTH-1:0] LONG_RST =
    WAIT_WIDTH'((LONG_WAIT_RST > WMAX_L) ? WMAX_L : longint'(LONG_WAIT_RST));

  logic [EXT_W-1:0]      data_ext;
  logic [EXT_W-1:0]      data_sat;
  logic [WAIT_WIDTH-1:0] data_w;

  // saturate at the counter maximum
  always_comb begin
    data_ext = EXT_W'(cfg_data);
    data_sat = (data_ext > WMAX) ? WMAX : data_ext;
    data_w   = data_sat[WAIT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_wait <= SHORT_RST;
      long_wait  <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_WAIT: short_wait <= data_w;
        REG_LONG_WAIT:  long_wait  <= data_w;
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/clpc_seq.sv
`include "char_lcd_parallel_controller_macros.svh"

module clpc_seq #(
  parameter int WAIT_WIDTH = clpc_pkg::WAIT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  clpc_pkg::cmd_t        cmd,
  input  logic [WAIT_WIDTH-1:0] short_wait,
  input  logic [WAIT_WIDTH-1:0] long_wait,
  output clpc_pkg::res_t        res
);
  import clpc_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  logic [3:0]            init_step;
  logic [3:0]            init_step_next;
  logic [WAIT_WIDTH-1:0] wait_count;
  logic [WAIT_WIDTH-1:0] wait_count_next;
  logic [7:0]            pending_byte;
  logic [7:0]            pending_byte_next;
  logic                  pending_is_data;
  logic                  pending_is_data_next;
  pins_t                 pins;
  pins_t                 pins_next;

  logic                  wait_done;
  logic [WAIT_WIDTH-1:0] wait_dec;
  logic [3:0]            step_inc;
  logic                  busy_cmd;
  logic                  rejected;
  logic [7:0]            cursor_byte;
  logic                  on_screen;

  always_comb begin
    wait_done   = (wait_count <= WAIT_WIDTH'(1));
    wait_dec    = wait_count - WAIT_WIDTH'(1);
    step_inc    = init_step + 4'd1;
    busy_cmd    = (cmd.action == ACT_INIT) || (cmd.action == ACT_WRITE_INSTR) ||
                  (cmd.action == ACT_WRITE_DATA) || (cmd.action == ACT_SET_CURSOR);
    on_screen   = (cmd.column < NUM_COLUMNS) && (cmd.row < NUM_ROWS);
    cursor_byte = on_screen ?
                  (CMD_SET_DDRAM | {1'b0, row_base(cmd.row[1:0]) + {2'b00, cmd.column}}) :
                  CMD_SET_DDRAM;
  end

  always_comb begin
    phase_next           = phase;
    init_step_next       = init_step;
    wait_count_next      = wait_count;
    pending_byte_next    = pending_byte;
    pending_is_data_next = pending_is_data;
    case (phase)
      PH_IDLE: begin
        if (cmd.action == ACT_INIT) begin
          init_step_next  = 4'd0;
          wait_count_next = long_wait;
          phase_next      = PH_INIT_WAIT;
        end else if (cmd.action == ACT_WRITE_INSTR || cmd.action == ACT_WRITE_DATA) begin
          pending_byte_next    = cmd.value;
          pending_is_data_next = (cmd.action == ACT_WRITE_DATA);
          wait_count_next      = short_wait;
          phase_next           = PH_POLL_PRE;
        end else if (cmd.action == ACT_SET_CURSOR) begin
          pending_byte_next    = cursor_byte;
          pending_is_data_next = 1'b0;
          wait_count_next      = short_wait;
          phase_next           = PH_POLL_PRE;
        end
      end
      PH_INIT_WAIT: begin
        if (wait_done) begin
          init_step_next = step_inc;
          if (step_inc < INIT_PRE_WAITS) begin
            wait_count_next = long_wait;
          end else if (step_inc < INIT_LAST_STEP) begin
            wait_count_next = '0;
            phase_next      = PH_INIT_STROBE;
          end else begin
            wait_count_next = '0;
            phase_next      = PH_IDLE;
          end
        end else begin
          wait_count_next = wait_dec;
        end
      end
      PH_INIT_STROBE: begin
        wait_count_next = long_wait;
        phase_next      = PH_INIT_WAIT;
      end
      PH_POLL_PRE: begin
        if (wait_done) begin
          wait_count_next = short_wait;
          phase_next      = PH_POLL_HIGH;
        end else begin
          wait_count_next = wait_dec;
        end
      end
      PH_POLL_HIGH: begin
        if (wait_done) begin
          if (cmd.bus_in[7]) begin
            wait_count_next = short_wait;
            phase_next      = PH_POLL_PRE;
          end else begin
            wait_count_next = '0;
            phase_next      = PH_WRITE_SETUP;
          end
        end else begin
          wait_count_next = wait_dec;
        end
      end
      PH_WRITE_SETUP:  phase_next = PH_WRITE_STROBE;
      PH_WRITE_STROBE: phase_next = PH_IDLE;
      default:         phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    pins_next = pins;
    rejected  = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (cmd.action == ACT_INIT) begin
          pins_next = '{data: 8'h00, drive: 1'b1, rs: 1'b0, rw: 1'b0, en: 1'b0};
        end else if (cmd.action == ACT_WRITE_INSTR || cmd.action == ACT_WRITE_DATA ||
                     cmd.action == ACT_SET_CURSOR) begin
          pins_next = '{data: 8'h00, drive: 1'b0, rs: 1'b0, rw: 1'b1, en: 1'b0};
        end
      end
      PH_INIT_WAIT: begin
        rejected = busy_cmd;
        if (wait_done && step_inc >= INIT_PRE_WAITS) begin
          if (step_inc < INIT_LAST_STEP) begin
            pins_next = '{data: init_byte(3'(step_inc - INIT_PRE_WAITS)), drive: 1'b1,
                          rs: 1'b0, rw: 1'b0, en: 1'b1};
          end else begin
            pins_next.en = 1'b0;
          end
        end
      end
      PH_INIT_STROBE: begin
        rejected     = busy_cmd;
        pins_next.en = 1'b0;
      end
      PH_POLL_PRE: begin
        rejected = busy_cmd;
        if (wait_done) begin
          pins_next = '{data: 8'h00, drive: 1'b0, rs: 1'b0, rw: 1'b1, en: 1'b1};
        end
      end
      PH_POLL_HIGH: begin
        rejected = busy_cmd;
        if (wait_done) begin
          if (cmd.bus_in[7]) begin
            pins_next = '{data: 8'h00, drive: 1'b0, rs: 1'b0, rw: 1'b1, en: 1'b0};
          end else begin
            pins_next = '{data: pending_byte, drive: 1'b1, rs: pending_is_data,
                          rw: 1'b0, en: 1'b0};
          end
        end
      end
      PH_WRITE_SETUP: begin
        rejected     = busy_cmd;
        pins_next.en = 1'b1;
      end
      PH_WRITE_STROBE: begin
        rejected     = busy_cmd;
        pins_next.en = 1'b0;
      end
      default: ;
    endcase

    res.lcd_enable = pins_next.en;
    res.lcd_select = pins_next.rs;
    res.lcd_read   = pins_next.rw;
    res.bus_out    = pins_next.drive ? pins_next.data : 8'h00;
    res.bus_drive  = pins_next.drive;
    res.ready_res  = (phase_next == PH_IDLE);
    res.rejected   = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      init_step       <= 4'd0;
      wait_count      <= '0;
      pending_byte    <= 8'h00;
      pending_is_data <= 1'b0;
      pins            <= '0;
    end else if (step) begin
      phase           <= phase_next;
      init_step       <= init_step_next;
      wait_count      <= wait_count_next;
      pending_byte    <= pending_byte_next;
      pending_is_data <= pending_is_data_next;
      pins            <= pins_next;
    end
  end

  `CLPC_ASSERT_NOW(a_undriven_bus_clear, clk, rst, !pins.drive, pins.data == 8'h00, "bus byte held while undriven")
  `CLPC_ASSERT_NOW(a_enable_in_strobe, clk, rst, pins.en, phase == PH_INIT_STROBE || phase == PH_POLL_HIGH || phase == PH_WRITE_STROBE, "enable high outside a strobe phase")
  `CLPC_ASSERT_NEXT(a_write_ends, clk, rst, step && phase == PH_WRITE_STROBE, phase == PH_IDLE && !pins.en, "write strobe did not end the command")
  `CLPC_ASSERT_NOW(a_init_step_range, clk, rst, 1'b1, init_step <= INIT_LAST_STEP, "init step out of range")
endmodule

FILE: rtl/char_lcd_parallel_controller.sv
// Channel  Dir   Payload   Handshake
// cmd      in    cmd_t     valid/ready, beat on both high
// rsp      out   res_t     valid/ready, beat on both high
// cfg      in    wait regs cfg_we, no back-pressure
//
// One tick or command per cycle unless rsp stalls; each beat in gives one beat out
// after passing cmd_q and then rsp_q; the sequencer state updates only on advance.
// A full output register still takes a new beat while the sink takes the old one.
// rst is synchronous and active high; it clears both valids and the sequencer.
module char_lcd_parallel_controller #(
  parameter int WAIT_WIDTH = clpc_pkg::WAIT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  clpc_stream_if.sink                     cmd,
  clpc_stream_if.source                   rsp,
  input  logic                            cfg_we,
  input  logic [clpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import clpc_pkg::*;

  logic                  cmd_full;
  cmd_t                  cmd_q;
  logic                  rsp_full;
  res_t                  rsp_q;
  res_t                  res;
  logic                  advance;
  logic [WAIT_WIDTH-1:0] short_wait;
  logic [WAIT_WIDTH-1:0] long_wait;

  assign advance     = cmd_full && (!rsp_full || rsp.ready);
  assign cmd.ready   = !cmd_full || advance;
  assign rsp.valid   = rsp_full;
  assign rsp.payload = rsp_q;

  clpc_cfg #(.WAIT_WIDTH(WAIT_WIDTH)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .short_wait (short_wait),
    .long_wait  (long_wait)
  );

  clpc_seq #(.WAIT_WIDTH(WAIT_WIDTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cmd        (cmd_q),
    .short_wait (short_wait),
    .long_wait  (long_wait),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full <= 1'b0;
    end else if (cmd.ready) begin
      cmd_full <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q <= cmd.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (advance) begin
      rsp_full <= 1'b1;
    end else if (rsp.ready) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= res;
    end
  end
endmodule
